### hdl/pbchs_pkg.sv
// shared types and constants for the partition block to chs translator
// no dependencies; imported by every module under hdl except pbchs_div
package pbchs_pkg;

    localparam int ENTRIES_PER_DRIVE = 5;
    localparam int DRIVES_DEF        = 2;
    localparam int SPB_DEF           = 2;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int SECT_W    = 35;
    localparam int DIV_STEPS = 4;
    localparam int SPT_W     = 6;
    localparam int HEADS_W   = 5;
    localparam int HEAD_W    = 4;
    localparam int CYL_W     = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0]         DH_BASE      = 8'hA0;
    localparam logic [HEADS_W-1:0] HEADS_MAX    = 5'd16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_INDEX    = 3'd1,
        ST_DISABLED     = 3'd2,
        ST_BEYOND_END   = 3'd3,
        ST_CYL_OVERFLOW = 3'd4,
        ST_LOADED       = 3'd5
    } pbchs_status_t;

    typedef enum logic [1:0] {
        CFG_SPT0   = 2'd0,
        CFG_HEADS0 = 2'd1,
        CFG_SPT1   = 2'd2,
        CFG_HEADS1 = 2'd3
    } pbchs_cfg_idx_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  part_index;
        logic        write_flag;
        logic [30:0] block_number;
        logic [31:0] entry_start;
        logic [31:0] entry_count;
        logic        entry_enable;
    } pbchs_in_t;

    typedef struct packed {
        pbchs_status_t status;
        logic          command;
        logic          drive;
        logic [5:0]    sector;
        logic [3:0]    head;
        logic [15:0]   cylinder;
        logic [7:0]    drive_head_byte;
    } pbchs_out_t;

    typedef struct packed {
        logic [SPT_W-1:0]   spt0;
        logic [HEADS_W-1:0] heads0;
        logic [SPT_W-1:0]   spt1;
        logic [HEADS_W-1:0] heads1;
    } pbchs_cfg_t;

    typedef struct packed {
        pbchs_status_t     status;
        logic              write_flag;
        logic              drive;
        logic [SECT_W-1:0] scaled;
        logic [31:0]       start;
    } pbchs_job_t;

    typedef struct packed {
        pbchs_status_t      status;
        logic               write_flag;
        logic               drive;
        logic [HEADS_W-1:0] heads;
    } pbchs_side1_t;

    typedef struct packed {
        pbchs_status_t    status;
        logic             write_flag;
        logic             drive;
        logic [SPT_W-1:0] sector;
    } pbchs_side2_t;

endpackage

### hdl/pbchs_div.sv
// pipelined restoring divider, up to K quotient bits per stage, sideband carried along
// depends on nothing; used twice by pbchs_back
module pbchs_div #(
    parameter int W      = 35,
    parameter int DW     = 6,
    parameter int K      = 4,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_dividend,
    input  logic [DW-1:0]     in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      out_quot,
    output logic [DW-1:0]     out_rem,
    output logic [SIDE_W-1:0] out_side
);

    localparam int S = (W + K - 1) / K;

    logic              valid_reg [S];
    logic [W-1:0]      quot_reg  [S];
    logic [DW-1:0]     rem_reg   [S];
    logic [DW-1:0]     dvs_reg   [S];
    logic [SIDE_W-1:0] side_reg  [S];

    genvar s;
    generate
        for (s = 0; s < S; s++) begin : g_stage
            localparam int NSTEP = (W - s * K < K) ? (W - s * K) : K;

            logic              valid_in;
            logic [W-1:0]      quot_in;
            logic [DW-1:0]     rem_in;
            logic [DW-1:0]     dvs_in;
            logic [SIDE_W-1:0] side_in;
            logic [W-1:0]      quot_next;
            logic [DW-1:0]     rem_next;
            logic [DW:0]       trial;

            if (s == 0) begin : g_first
                assign valid_in = in_valid;
                assign quot_in  = in_dividend;
                assign rem_in   = '0;
                assign dvs_in   = in_divisor;
                assign side_in  = in_side;
            end else begin : g_rest
                assign valid_in = valid_reg[s-1];
                assign quot_in  = quot_reg[s-1];
                assign rem_in   = rem_reg[s-1];
                assign dvs_in   = dvs_reg[s-1];
                assign side_in  = side_reg[s-1];
            end

            always_comb begin
                quot_next = quot_in;
                rem_next  = rem_in;
                trial     = '0;
                for (int j = 0; j < NSTEP; j++) begin
                    trial     = {rem_next, quot_next[W-1]};
                    quot_next = {quot_next[W-2:0], 1'b0};
                    if (trial >= {1'b0, dvs_in}) begin
                        trial        = trial - {1'b0, dvs_in};
                        quot_next[0] = 1'b1;
                    end
                    rem_next = trial[DW-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    quot_reg[s] <= quot_next;
                    rem_reg[s]  <= rem_next;
                    dvs_reg[s]  <= dvs_in;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[S-1];
    assign out_quot  = quot_reg[S-1];
    assign out_rem   = rem_reg[S-1];
    assign out_side  = side_reg[S-1];

endmodule

### hdl/pbchs_front.sv
// front end: partition table, item accept and classification into jobs
// depends on pbchs_pkg
module pbchs_front import pbchs_pkg::*; #(
    parameter int DRIVES = DRIVES_DEF,
    parameter int SPB    = SPB_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pbchs_in_t  s_data,
    input  logic       q_ready,
    output logic       q_push,
    output pbchs_job_t q_data
);

    localparam int DEPTH = ENTRIES_PER_DRIVE * DRIVES;
    localparam int IDX_W = $clog2(DEPTH);

    logic [31:0]      start_reg [DEPTH];
    logic [31:0]      count_reg [DEPTH];
    logic [DEPTH-1:0] enable_reg;

    logic              idx_ok;
    logic [IDX_W-1:0]  idx;
    logic [SECT_W-1:0] scaled;
    logic [SECT_W-1:0] end_sum;
    logic              beyond;
    logic              load_we;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    assign idx_ok  = s_data.part_index < 4'(DEPTH);
    assign idx     = s_data.part_index[IDX_W-1:0];
    assign scaled  = SECT_W'(s_data.block_number) * SECT_W'(SPB);
    assign end_sum = scaled + SECT_W'(SPB);
    assign load_we = q_push && idx_ok && (s_data.mode == MODE_LOAD);

    always_comb begin
        q_data.write_flag = s_data.write_flag;
        q_data.drive      = s_data.part_index >= 4'(ENTRIES_PER_DRIVE);
        q_data.scaled     = scaled;
        q_data.start      = '0;
        beyond            = 1'b0;
        if (!idx_ok) begin
            q_data.status = ST_BAD_INDEX;
        end else if (s_data.mode == MODE_LOAD) begin
            q_data.status = ST_LOADED;
        end else if (!enable_reg[idx]) begin
            q_data.status = ST_DISABLED;
        end else begin
            beyond        = end_sum > SECT_W'(count_reg[idx]);
            q_data.start  = start_reg[idx];
            q_data.status = beyond ? ST_BEYOND_END : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
        end else if (load_we) begin
            enable_reg[idx] <= s_data.entry_enable;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            start_reg[idx] <= s_data.entry_start;
            count_reg[idx] <= s_data.entry_count;
        end
    end

endmodule

### hdl/pbchs_fifo.sv
// short job queue between front and back ends
// depends on pbchs_pkg
module pbchs_fifo import pbchs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pbchs_job_t push_data,
    output logic       push_ready,
    input  logic       pop,
    output logic       head_valid,
    output pbchs_job_t head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pbchs_job_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_data  = mem_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### hdl/pbchs_back.sv
// back end: start add, two pipelined divisions and the result register
// depends on pbchs_pkg and pbchs_div
module pbchs_back import pbchs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  pbchs_job_t q_data,
    output logic       q_pop,
    input  pbchs_cfg_t cfg,
    output logic       m_valid,
    input  logic       m_ready,
    output pbchs_out_t m_data
);

    localparam int SIDE1_W = $bits(pbchs_side1_t);
    localparam int SIDE2_W = $bits(pbchs_side2_t);

    logic en;

    logic               a_valid_reg;
    logic [SECT_W-1:0]  a_sect_reg;
    logic [SPT_W-1:0]   a_spt_reg;
    pbchs_side1_t       a_side_reg;
    logic [SPT_W-1:0]   spt_raw, spt_eff;
    logic [HEADS_W-1:0] heads_raw, heads_eff;
    pbchs_side1_t       a_side_next;

    logic               d1_valid;
    logic [SECT_W-1:0]  d1_quot;
    logic [SPT_W-1:0]   d1_rem;
    logic [SIDE1_W-1:0] d1_side_bits;
    pbchs_side1_t       d1_side;
    pbchs_side2_t       d2_side_in;

    logic               d2_valid;
    logic [SECT_W-1:0]  d2_quot;
    logic [HEADS_W-1:0] d2_rem;
    logic [SIDE2_W-1:0] d2_side_bits;
    pbchs_side2_t       d2_side;

    logic               m_valid_reg;
    pbchs_out_t         m_data_reg, m_data_next;
    logic [HEAD_W-1:0]  head;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    always_comb begin
        spt_raw   = q_data.drive ? cfg.spt1 : cfg.spt0;
        heads_raw = q_data.drive ? cfg.heads1 : cfg.heads0;
        spt_eff   = (spt_raw == '0) ? SPT_W'(1) : spt_raw;
        if (heads_raw == '0) begin
            heads_eff = HEADS_W'(1);
        end else if (heads_raw > HEADS_MAX) begin
            heads_eff = HEADS_MAX;
        end else begin
            heads_eff = heads_raw;
        end
        a_side_next.status     = q_data.status;
        a_side_next.write_flag = q_data.write_flag;
        a_side_next.drive      = q_data.drive;
        a_side_next.heads      = heads_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sect_reg <= q_data.scaled + SECT_W'(q_data.start);
            a_spt_reg  <= spt_eff;
            a_side_reg <= a_side_next;
        end
    end

    pbchs_div #(
        .W      (SECT_W),
        .DW     (SPT_W),
        .K      (DIV_STEPS),
        .SIDE_W (SIDE1_W)
    ) u_div_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (a_valid_reg),
        .in_dividend (a_sect_reg),
        .in_divisor  (a_spt_reg),
        .in_side     (a_side_reg),
        .out_valid   (d1_valid),
        .out_quot    (d1_quot),
        .out_rem     (d1_rem),
        .out_side    (d1_side_bits)
    );

    assign d1_side = pbchs_side1_t'(d1_side_bits);

    always_comb begin
        d2_side_in.status     = d1_side.status;
        d2_side_in.write_flag = d1_side.write_flag;
        d2_side_in.drive      = d1_side.drive;
        d2_side_in.sector     = d1_rem + SPT_W'(1);
    end

    pbchs_div #(
        .W      (SECT_W),
        .DW     (HEADS_W),
        .K      (DIV_STEPS),
        .SIDE_W (SIDE2_W)
    ) u_div_cyl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d1_valid),
        .in_dividend (d1_quot),
        .in_divisor  (d1_side.heads),
        .in_side     (d2_side_in),
        .out_valid   (d2_valid),
        .out_quot    (d2_quot),
        .out_rem     (d2_rem),
        .out_side    (d2_side_bits)
    );

    assign d2_side = pbchs_side2_t'(d2_side_bits);
    assign head    = d2_rem[HEAD_W-1:0];

    always_comb begin
        m_data_next.status          = d2_side.status;
        m_data_next.command         = 1'b0;
        m_data_next.drive           = 1'b0;
        m_data_next.sector          = '0;
        m_data_next.head            = '0;
        m_data_next.cylinder        = '0;
        m_data_next.drive_head_byte = DH_BASE;
        if (d2_side.status == ST_OK) begin
            m_data_next.status          = (d2_quot[SECT_W-1:CYL_W] != '0) ?
                                          ST_CYL_OVERFLOW : ST_OK;
            m_data_next.command         = d2_side.write_flag;
            m_data_next.drive           = d2_side.drive;
            m_data_next.sector          = d2_side.sector;
            m_data_next.head            = head;
            m_data_next.cylinder        = d2_quot[CYL_W-1:0];
            m_data_next.drive_head_byte = DH_BASE | {3'b000, d2_side.drive, 4'b0000}
                                          | {4'b0000, head};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/partition_block_to_chs.sv
// top level: block request to cylinder/head/sector translation, apb register file
// depends on pbchs_pkg, pbchs_front, pbchs_fifo, pbchs_back
//
//   port group   dir   handshake               beat
//   s_*          in    s_valid / s_ready       one load or translate request
//   m_*          out   m_valid / m_ready       one status/chs result
//   apb          in    psel, penable, pready   one register write or read
//
// one beat per cycle in and out when neither side stalls
// result path: queue write, start add, two 9-stage dividers, result register
// the divider pipelines advance together and hold while a result waits on m_ready
// the job queue lets requests keep arriving while the back end holds
// reset clears the queue, pipeline valids and entry enables
// reset sets the divisor registers to 63 sectors and 16 heads
module partition_block_to_chs import pbchs_pkg::*; #(
    parameter int DRIVES            = DRIVES_DEF,
    parameter int SECTORS_PER_BLOCK = SPB_DEF,
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pbchs_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pbchs_out_t            m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    pbchs_cfg_t     cfg_reg, cfg_next;
    pbchs_cfg_idx_t cfg_idx;
    logic           cfg_we;

    logic       q_push, q_ready, q_pop, q_valid;
    pbchs_job_t q_in, q_out;

    assign pready  = 1'b1;
    assign cfg_idx = pbchs_cfg_idx_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                CFG_SPT0:   cfg_next.spt0   = pwdata[SPT_W-1:0];
                CFG_HEADS0: cfg_next.heads0 = pwdata[HEADS_W-1:0];
                CFG_SPT1:   cfg_next.spt1   = pwdata[SPT_W-1:0];
                CFG_HEADS1: cfg_next.heads1 = pwdata[HEADS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_SPT0:   prdata = APB_DATA_W'(cfg_reg.spt0);
            CFG_HEADS0: prdata = APB_DATA_W'(cfg_reg.heads0);
            CFG_SPT1:   prdata = APB_DATA_W'(cfg_reg.spt1);
            CFG_HEADS1: prdata = APB_DATA_W'(cfg_reg.heads1);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spt0   <= SPT_W'(63);
            cfg_reg.heads0 <= HEADS_MAX;
            cfg_reg.spt1   <= SPT_W'(63);
            cfg_reg.heads1 <= HEADS_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pbchs_front #(
        .DRIVES (DRIVES),
        .SPB    (SECTORS_PER_BLOCK)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    pbchs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    pbchs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/sv/partition_block_to_chs_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for partition_block_to_chs: table loads and chs translations
// checked beat by beat against an in-bench predictor, divisors set over apb
// depends on pbchs_pkg and the partition_block_to_chs rtl
module partition_block_to_chs_tb;
    import pbchs_pkg::*;

    localparam int TABLE_DEPTH     = ENTRIES_PER_DRIVE * DRIVES_DEF;
    localparam int DIRECTED_ROWS   = 26;
    localparam int ITEMS_PER_PHASE = 218;
    localparam int PHASES          = 7;
    localparam int SETTLE_CYCLES   = 64;

    typedef struct {
        pbchs_in_t     req;
        bit            fixed;
        pbchs_status_t fixed_status;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    pbchs_in_t             s_data;
    logic                  m_valid;
    logic                  m_ready;
    pbchs_out_t            m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [31:0]        part_start [TABLE_DEPTH];
    logic [31:0]        part_len   [TABLE_DEPTH];
    logic               part_on    [TABLE_DEPTH];
    logic [SPT_W-1:0]   geo_spt    [2];
    logic [HEADS_W-1:0] geo_heads  [2];

    pbchs_out_t    pending_chs [$];
    directed_row_t directed [DIRECTED_ROWS];
    int unsigned   rows_built;
    int unsigned   mismatches;
    int unsigned   rx_beats;
    bit            tx_burst;
    bit            rx_burst;
    pbchs_out_t    oldest_chs;

    partition_block_to_chs dut (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic pbchs_out_t translate_request(input pbchs_in_t req);
        pbchs_out_t  res;
        logic [63:0] sect;
        logic [63:0] spt;
        logic [63:0] heads;
        logic [63:0] track;
        logic [63:0] cyl;
        logic        drv;
        res = '0;
        res.drive_head_byte = DH_BASE;
        if (req.part_index >= TABLE_DEPTH) begin
            res.status = ST_BAD_INDEX;
            return res;
        end
        if (req.mode == MODE_LOAD) begin
            part_start[req.part_index] = req.entry_start;
            part_len[req.part_index]   = req.entry_count;
            part_on[req.part_index]    = req.entry_enable;
            res.status = ST_LOADED;
            return res;
        end
        if (!part_on[req.part_index]) begin
            res.status = ST_DISABLED;
            return res;
        end
        sect = 64'(req.block_number) * SPB_DEF;
        if (sect + SPB_DEF > 64'(part_len[req.part_index])) begin
            res.status = ST_BEYOND_END;
            return res;
        end
        sect = sect + 64'(part_start[req.part_index]);
        drv   = 1'(req.part_index / ENTRIES_PER_DRIVE);
        spt   = 64'(geo_spt[drv]);
        heads = 64'(geo_heads[drv]);
        if (spt == 0) spt = 1;
        if (heads == 0) heads = 1;
        if (heads > 64'(HEADS_MAX)) heads = 64'(HEADS_MAX);
        track = sect / spt;
        cyl   = track / heads;
        res.status          = (cyl > 64'hFFFF) ? ST_CYL_OVERFLOW : ST_OK;
        res.command         = req.write_flag;
        res.drive           = drv;
        res.sector          = 6'(sect % spt + 1);
        res.head            = 4'(track % heads);
        res.cylinder        = 16'(cyl);
        res.drive_head_byte = DH_BASE | {3'b000, drv, res.head};
        return res;
    endfunction

    function automatic pbchs_in_t make_request();
        pbchs_in_t   req;
        logic [127:0] noise;
        logic [31:0] len;
        logic [31:0] top;
        int unsigned pick;
        int          live[$];
        noise = {$urandom, $urandom, $urandom, $urandom};
        req   = noise[$bits(pbchs_in_t)-1:0];
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (part_on[i]) live.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 15 || live.size() == 0) begin
            req.mode = MODE_LOAD;
            if ($urandom_range(0, 19) == 0)
                req.part_index = 4'($urandom_range(TABLE_DEPTH, 15));
            else
                req.part_index = 4'($urandom_range(0, TABLE_DEPTH - 1));
            case ($urandom_range(0, 2))
                0: req.entry_start = $urandom_range(0, 4095);
                1: req.entry_start = $urandom;
                default: req.entry_start = 32'hFFFF_FFFF - $urandom_range(0, 4095);
            endcase
            case ($urandom_range(0, 2))
                0: req.entry_count = $urandom_range(0, 8192);
                1: req.entry_count = $urandom;
                default: req.entry_count = 32'hFFFF_FFFF;
            endcase
            req.entry_enable = ($urandom_range(0, 7) != 0);
        end else if (pick < 22) begin
            // any index, any block
            req.mode = MODE_XLATE;
        end else begin
            req.mode       = MODE_XLATE;
            req.part_index = 4'(live[$urandom_range(0, live.size() - 1)]);
            len = part_len[req.part_index];
            top = (len < 2) ? 32'd0 : (len - 2) / 2;
            case ($urandom_range(0, 5))
                0, 1: req.block_number = 31'($urandom_range(0, (top < 2047) ? top : 2047));
                2, 3: req.block_number = 31'($urandom_range(0, top));
                4: req.block_number = 31'(top);
                default: req.block_number = 31'(top + 1);
            endcase
        end
        return req;
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                         want, got);
        end
    endfunction

    task automatic add_row(input logic mode, input logic [3:0] idx, input logic wr,
                           input logic [30:0] blk, input logic [31:0] start,
                           input logic [31:0] count, input logic en, input bit fixed,
                           input pbchs_status_t st);
        directed[rows_built].req          = {mode, idx, wr, blk, start, count, en};
        directed[rows_built].fixed        = fixed;
        directed[rows_built].fixed_status = st;
        rows_built++;
    endtask

    task automatic send_request(input pbchs_in_t req, input int unsigned gap,
                                input bit fixed, input pbchs_status_t st);
        pbchs_out_t want;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        want = translate_request(req);
        if (fixed) begin
            want                 = '0;
            want.status          = st;
            want.drive_head_byte = DH_BASE;
        end
        pending_chs.push_back(want);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_chs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_divisor(input pbchs_cfg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_SPT0:   geo_spt[0]   = value[SPT_W-1:0];
            CFG_HEADS0: geo_heads[0] = value[HEADS_W-1:0];
            CFG_SPT1:   geo_spt[1]   = value[SPT_W-1:0];
            CFG_HEADS1: geo_heads[1] = value[HEADS_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic apply_geometry(input int unsigned spt0, input int unsigned heads0,
                                  input int unsigned spt1, input int unsigned heads1);
        write_divisor(CFG_SPT0, spt0);
        write_divisor(CFG_HEADS0, heads0);
        write_divisor(CFG_SPT1, spt1);
        write_divisor(CFG_HEADS1, heads1);
    endtask

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected, actual %h", $realtime,
                             m_data);
            end else begin
                oldest_chs = pending_chs.pop_front();
                check_field("status", oldest_chs.status, m_data.status);
                check_field("command", oldest_chs.command, m_data.command);
                check_field("drive", oldest_chs.drive, m_data.drive);
                check_field("sector", oldest_chs.sector, m_data.sector);
                check_field("head", oldest_chs.head, m_data.head);
                check_field("cylinder", oldest_chs.cylinder, m_data.cylinder);
                check_field("drive_head_byte", oldest_chs.drive_head_byte,
                            m_data.drive_head_byte);
            end
        end
    end

    initial begin
        int unsigned stall;
        rx_beats = 0;
        rx_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_beats % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_beats++;
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        mismatches = 0;
        rows_built = 0;
        tx_burst   = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            part_start[i] = '0;
            part_len[i]   = '0;
            part_on[i]    = 1'b0;
        end
        geo_spt[0]   = 6'd63;
        geo_spt[1]   = 6'd63;
        geo_heads[0] = 5'd16;
        geo_heads[1] = 5'd16;

        add_row(MODE_XLATE, 4'd0, 1'b0, 31'd0, 32'd0, 32'd0, 1'b0, 1, ST_DISABLED);
        add_row(MODE_XLATE, 4'd15, 1'b1, '1, '1, '1, 1'b1, 1, ST_BAD_INDEX);
        add_row(MODE_LOAD, 4'd10, 1'b0, 31'd0, '1, '1, 1'b1, 1, ST_BAD_INDEX);
        add_row(MODE_LOAD, 4'd15, 1'b1, '1, '1, '1, 1'b1, 1, ST_BAD_INDEX);
        add_row(MODE_LOAD, 4'd0, 1'b1, '1, 32'd0, '1, 1'b1, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd0, 1'b0, 31'd0, '1, '1, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd0, 1'b1, 31'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 1, ST_BEYOND_END);
        add_row(MODE_XLATE, 4'd0, 1'b1, 31'h7FFF_FFFE, 32'd0, 32'd0, 1'b1, 0, ST_OK);
        add_row(MODE_LOAD, 4'd4, 1'b0, 31'd0, '1, '1, 1'b1, 1, ST_LOADED);
        // start plus block above 32 bits
        add_row(MODE_XLATE, 4'd4, 1'b0, 31'h7FFF_FFFE, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd4, 1'b1, 31'd0, '1, 32'd0, 1'b1, 0, ST_OK);
        add_row(MODE_LOAD, 4'd9, 1'b1, 31'd5, 32'd0, 32'd0, 1'b1, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd9, 1'b0, 31'd0, 32'd0, 32'd0, 1'b0, 1, ST_BEYOND_END);
        add_row(MODE_LOAD, 4'd5, 1'b0, 31'd0, 32'd100, 32'd10, 1'b0, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd5, 1'b0, 31'd0, 32'd0, 32'd0, 1'b1, 1, ST_DISABLED);
        add_row(MODE_LOAD, 4'd5, 1'b0, 31'd0, 32'd1000, 32'd2, 1'b1, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd5, 1'b1, 31'd0, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd5, 1'b0, 31'd1, 32'd0, 32'd0, 1'b0, 1, ST_BEYOND_END);
        add_row(MODE_LOAD, 4'd1, 1'b0, 31'd0, 32'd62, 32'd64, 1'b1, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd1, 1'b0, 31'd0, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd1, 1'b1, 31'd1, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd1, 1'b0, 31'd31, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd1, 1'b0, 31'd32, 32'd0, 32'd0, 1'b0, 1, ST_BEYOND_END);
        add_row(MODE_LOAD, 4'd3, 1'b0, 31'd0, 32'd1007, 32'd4, 1'b1, 1, ST_LOADED);
        add_row(MODE_XLATE, 4'd3, 1'b0, 31'd0, 32'd0, 32'd0, 1'b0, 0, ST_OK);
        add_row(MODE_XLATE, 4'd3, 1'b1, 31'd1, 32'd0, 32'd0, 1'b0, 0, ST_OK);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_request(directed[i].req, $urandom_range(0, 9), directed[i].fixed,
                         directed[i].fixed_status);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: apply_geometry(1, 1, 1, 1);
                    2: apply_geometry(0, 0, 0, 0);
                    3: apply_geometry(63, 31, 63, 17);
                    4: apply_geometry(63, 16, 1, 1);
                    default: apply_geometry($urandom_range(0, 63), $urandom_range(0, 31),
                                            $urandom_range(0, 63), $urandom_range(0, 31));
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
                send_request(make_request(), tx_burst ? 0 : $urandom_range(0, 9), 0, ST_OK);
            end
        end
        settle();

        if (mismatches == 0 && pending_chs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
